// ===== rtl/pat_pkg.sv =====
// ----------------------------------------------------------------------------
// pat_pkg
// Shared widths, register indexes and reset values of the angle tracker.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int unsigned PosW   = 16;  // measured_pos, target_pos, angle_cmd
  localparam int unsigned GainW  = 21;  // signed Q5.16 gains
  localparam int unsigned DzW    = 15;  // dead_zone
  localparam int unsigned ErrW   = 17;  // target - measured
  localparam int unsigned DiffW  = 18;  // error - previous error
  localparam int unsigned SumW   = 32;  // saturating integral
  localparam int unsigned AccW   = 40;  // Q24.16 angle accumulator
  localparam int unsigned FracW  = 16;
  localparam int unsigned ProdPW = GainW + ErrW;
  localparam int unsigned ProdIW = GainW + SumW;
  localparam int unsigned ProdDW = GainW + DiffW;
  localparam int unsigned CorrW  = ProdIW + 1;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = GainW;
  localparam int unsigned InDataW  = 2 * PosW;
  localparam int unsigned OutDataW = PosW;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_DEAD_ZONE   = 3'd3,
    REG_START_ANGLE = 3'd4
  } cfg_reg_e;

  localparam logic signed [GainW-1:0] GainPRst = 21'sd66;
  localparam logic signed [GainW-1:0] GainIRst = 21'sd0;
  localparam logic signed [GainW-1:0] GainDRst = 21'sd1049;
  localparam logic [DzW-1:0]          DeadZoneRst = 15'd3;
  localparam logic signed [PosW-1:0]  StartAngleRst = 16'sd0;

endpackage

// ===== rtl/pid_angle_tracker.sv =====
// ----------------------------------------------------------------------------
// pid_angle_tracker
// One axis of a servo tracking loop: PID correction on the position error,
// accumulated into a Q24.16 angle, integer angle out.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream: one item per camera update, measured and target position.
//  - Output stream: one angle command per input item, in order.
//  - Config port: gains, dead zone and start angle, written by index while
//    the block is idle. Writing the start angle reloads the accumulator.
//  - Six register stages: input, integral, multiply, correction sum,
//    accumulate, output. An accepted item shows on m_axis_tvalid once it
//    has moved through every stage in that order.
//  - One item per cycle unless the output stalls; the integral, previous
//    error and accumulator each close their loop in a single stage.
//  - Each stage advances when the next one is empty or moving, so empty
//    stages keep taking items while a result waits at the output; the input
//    stalls only once all six stages are full.
//  - Reset loads the register defaults, clears the integral and previous
//    error, loads the start angle into the accumulator and empties the pipe.
// ----------------------------------------------------------------------------
module pid_angle_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pat_pkg::InDataW-1:0]         s_axis_tdata,  // measured_pos, target_pos
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pat_pkg::OutDataW-1:0]        m_axis_tdata,  // angle_cmd
  // configuration
  input  logic                                cfg_we_i,
  input  logic [pat_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [pat_pkg::CfgDataW-1:0]        cfg_wdata_i
);

  localparam int unsigned PosW   = pat_pkg::PosW;
  localparam int unsigned GainW  = pat_pkg::GainW;
  localparam int unsigned DzW    = pat_pkg::DzW;
  localparam int unsigned ErrW   = pat_pkg::ErrW;
  localparam int unsigned DiffW  = pat_pkg::DiffW;
  localparam int unsigned SumW   = pat_pkg::SumW;
  localparam int unsigned AccW   = pat_pkg::AccW;
  localparam int unsigned FracW  = pat_pkg::FracW;
  localparam int unsigned ProdPW = pat_pkg::ProdPW;
  localparam int unsigned ProdIW = pat_pkg::ProdIW;
  localparam int unsigned ProdDW = pat_pkg::ProdDW;
  localparam int unsigned CorrW  = pat_pkg::CorrW;
  localparam int unsigned IntW   = AccW - FracW;

  // configuration registers
  logic signed [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [DzW-1:0]          dead_zone_q;

  // loop state
  logic signed [ErrW-1:0]  prev_error_q;
  logic signed [SumW-1:0]  error_sum_q;
  logic signed [AccW-1:0]  angle_acc_q;

  // stage valid bits: a input, b integral, c multiply, d sum, e acc, f out
  logic vld_a_q, vld_b_q, vld_c_q, vld_d_q, vld_e_q, vld_f_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
  logic mv_in, mv_ab, mv_bc, mv_cd, mv_de, mv_ef, out_hs;

  // stage payloads
  logic signed [ErrW-1:0]   err_a_q, err_b_q;
  logic signed [DiffW-1:0]  diff_a_q, diff_b_q;
  logic                     dz_a_q, dz_b_q, dz_c_q;
  logic signed [SumW-1:0]   sum_b_q;
  logic signed [ProdPW-1:0] prod_p_q;
  logic signed [ProdIW-1:0] prod_i_q;
  logic signed [ProdDW-1:0] prod_d_q;
  logic signed [CorrW-1:0]  corr_q;
  logic [PosW-1:0]          angle_cmd_q;

  // ---------------------------------------------------------------- handshake
  assign rdy_f = ~vld_f_q | m_axis_tready;
  assign rdy_e = ~vld_e_q | rdy_f;
  assign rdy_d = ~vld_d_q | rdy_e;
  assign rdy_c = ~vld_c_q | rdy_d;
  assign rdy_b = ~vld_b_q | rdy_c;
  assign rdy_a = ~vld_a_q | rdy_b;

  assign mv_in  = s_axis_tvalid & rdy_a;
  assign mv_ab  = vld_a_q & rdy_b;
  assign mv_bc  = vld_b_q & rdy_c;
  assign mv_cd  = vld_c_q & rdy_d;
  assign mv_de  = vld_d_q & rdy_e;
  assign mv_ef  = vld_e_q & rdy_f;
  assign out_hs = vld_f_q & m_axis_tready;

  assign s_axis_tready = rdy_a;
  assign m_axis_tvalid = vld_f_q;
  assign m_axis_tdata  = angle_cmd_q;

  // ---------------------------------------------------------- input stage
  logic signed [PosW-1:0]  meas_in, targ_in;
  logic signed [ErrW-1:0]  meas_x, err_in;
  logic signed [DiffW-1:0] diff_in;
  logic [ErrW-1:0]         mag_in;
  logic                    dz_in;

  assign meas_in = $signed(s_axis_tdata[PosW-1:0]);
  assign targ_in = $signed(s_axis_tdata[2*PosW-1:PosW]);
  assign meas_x  = ErrW'(meas_in);
  assign err_in  = ErrW'(targ_in) - meas_x;
  assign diff_in = DiffW'(err_in) - DiffW'(prev_error_q);
  assign mag_in  = meas_in[PosW-1] ? ErrW'(-meas_x) : ErrW'(meas_x);
  assign dz_in   = mag_in < ErrW'(dead_zone_q);

  // ------------------------------------------------------- integral stage
  logic signed [SumW:0]   sum_wide;
  logic signed [SumW-1:0] sum_sat;

  assign sum_wide = (SumW+1)'(error_sum_q) + (SumW+1)'(err_a_q);
  always_comb begin
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      // hold at the rail on the side of the true sign
      sum_sat = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
  end

  // -------------------------------------------------------- multiply stage
  logic signed [ProdPW-1:0] prod_p_d;
  logic signed [ProdIW-1:0] prod_i_d;
  logic signed [ProdDW-1:0] prod_d_d;

  assign prod_p_d = ProdPW'(gain_p_q) * ProdPW'(err_b_q);
  assign prod_i_d = ProdIW'(gain_i_q) * ProdIW'(sum_b_q);
  assign prod_d_d = ProdDW'(gain_d_q) * ProdDW'(diff_b_q);

  // ----------------------------------------------------- correction stage
  logic signed [CorrW-1:0] corr_d;

  assign corr_d = dz_c_q ? '0
                         : CorrW'(prod_p_q) + CorrW'(prod_i_q) + CorrW'(prod_d_q);

  // --------------------------------------------------- accumulator stage
  logic signed [CorrW:0]  acc_wide;
  logic signed [AccW-1:0] acc_sat;

  assign acc_wide = (CorrW+1)'(angle_acc_q) + (CorrW+1)'(corr_q);
  always_comb begin
    if (acc_wide[CorrW:AccW-1] != {(CorrW-AccW+2){acc_wide[AccW-1]}}) begin
      acc_sat = acc_wide[CorrW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_sat = acc_wide[AccW-1:0];
    end
  end

  // ------------------------------------------------------- output stage
  logic signed [IntW-1:0] whole;
  logic [PosW-1:0]        angle_cmd_d;

  // floor, then step negative values with a fraction back toward zero
  assign whole = $signed(angle_acc_q[AccW-1:FracW])
               + IntW'(angle_acc_q[AccW-1] & (|angle_acc_q[FracW-1:0]));
  always_comb begin
    if (whole[IntW-1:PosW-1] != {(IntW-PosW+1){whole[IntW-1]}}) begin
      angle_cmd_d = whole[IntW-1] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end else begin
      angle_cmd_d = whole[PosW-1:0];
    end
  end

  // ------------------------------------------------ control and state regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= pat_pkg::GainPRst;
      gain_i_q     <= pat_pkg::GainIRst;
      gain_d_q     <= pat_pkg::GainDRst;
      dead_zone_q  <= pat_pkg::DeadZoneRst;
      prev_error_q <= '0;
      error_sum_q  <= '0;
      angle_acc_q  <= {{(AccW-PosW-FracW){pat_pkg::StartAngleRst[PosW-1]}},
                       pat_pkg::StartAngleRst, {FracW{1'b0}}};
      vld_a_q      <= 1'b0;
      vld_b_q      <= 1'b0;
      vld_c_q      <= 1'b0;
      vld_d_q      <= 1'b0;
      vld_e_q      <= 1'b0;
      vld_f_q      <= 1'b0;
    end else begin
      vld_a_q <= (vld_a_q & ~mv_ab) | mv_in;
      vld_b_q <= (vld_b_q & ~mv_bc) | mv_ab;
      vld_c_q <= (vld_c_q & ~mv_cd) | mv_bc;
      vld_d_q <= (vld_d_q & ~mv_de) | mv_cd;
      vld_e_q <= (vld_e_q & ~mv_ef) | mv_de;
      vld_f_q <= (vld_f_q & ~out_hs) | mv_ef;

      if (mv_in) begin
        prev_error_q <= err_in;
      end
      if (mv_ab) begin
        error_sum_q <= sum_sat;
      end
      if (mv_de) begin
        angle_acc_q <= acc_sat;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          pat_pkg::REG_GAIN_P:    gain_p_q    <= $signed(cfg_wdata_i[GainW-1:0]);
          pat_pkg::REG_GAIN_I:    gain_i_q    <= $signed(cfg_wdata_i[GainW-1:0]);
          pat_pkg::REG_GAIN_D:    gain_d_q    <= $signed(cfg_wdata_i[GainW-1:0]);
          pat_pkg::REG_DEAD_ZONE: dead_zone_q <= cfg_wdata_i[DzW-1:0];
          pat_pkg::REG_START_ANGLE: begin
            angle_acc_q <= {{(AccW-PosW-FracW){cfg_wdata_i[PosW-1]}},
                            cfg_wdata_i[PosW-1:0], {FracW{1'b0}}};
          end
          default: ;
        endcase
      end
    end
  end

  // ------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (mv_in) begin
      err_a_q  <= err_in;
      diff_a_q <= diff_in;
      dz_a_q   <= dz_in;
    end
    if (mv_ab) begin
      err_b_q  <= err_a_q;
      diff_b_q <= diff_a_q;
      sum_b_q  <= sum_sat;
      dz_b_q   <= dz_a_q;
    end
    if (mv_bc) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
      dz_c_q   <= dz_b_q;
    end
    if (mv_cd) begin
      corr_q <= corr_d;
    end
    if (mv_ef) begin
      angle_cmd_q <= angle_cmd_d;
    end
  end

  // ------------------------------------------------------------ checks
`ifndef SYNTHESIS
  logic [5:0] vld_vec;
  assign vld_vec = {vld_f_q, vld_e_q, vld_d_q, vld_c_q, vld_b_q, vld_a_q};

  a_sum_moves_with_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mv_ab |=> $stable(error_sum_q))
    else $error("integral changed without an item entering the integral stage");

  a_acc_moves_with_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!mv_de && !(cfg_we_i && cfg_idx_i == pat_pkg::REG_START_ANGLE))
      |=> $stable(angle_acc_q))
    else $error("accumulator changed without an item or a start angle write");

  a_fill_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_in && !out_hs) |=> $countones(vld_vec) == $past($countones(vld_vec)) + 1)
    else $error("accepted item not counted in the pipeline");

  a_drain_on_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!mv_in && out_hs) |=> $countones(vld_vec) == $past($countones(vld_vec)) - 1)
    else $error("delivered item not removed from the pipeline");
`endif

endmodule

// ===== bench/pid_angle_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// pid_angle_tracker_tb
// Self-checking bench for the angle tracker: drives position items in bursts
// against a stalling receiver, and predicts every angle command in order.
// ----------------------------------------------------------------------------
module pid_angle_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pat_pkg::*;

  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandPhases  = 6;
  localparam int unsigned PhaseItems  = 200;
  localparam int unsigned SoakUp      = 80;
  localparam int unsigned SoakDown    = 80;
  localparam int unsigned ReportMax   = 10;

  localparam longint SumMax = 64'sd2147483647;
  localparam longint SumMin = -SumMax - 1;
  localparam longint AccMax = 64'sd549755813887;
  localparam longint AccMin = -AccMax - 1;
  localparam longint OutMax = 64'sd32767;
  localparam longint OutMin = -OutMax - 1;
  localparam longint FracOne = 64'sd1 <<< FracW;

  localparam logic [CfgDataW-1:0] GainMax = {1'b0, {(GainW-1){1'b1}}};
  localparam logic [CfgDataW-1:0] GainMin = {1'b1, {(GainW-1){1'b0}}};
  localparam logic [DzW-1:0]      DzMax   = '1;
  localparam logic [PosW-1:0]     PosMax  = {1'b0, {(PosW-1){1'b1}}};
  localparam logic [PosW-1:0]     PosMin  = {1'b1, {(PosW-1){1'b0}}};

  // Predicts the angle command of every accepted item and checks results in order.
  class angle_scoreboard;
    longint gain_p, gain_i, gain_d, dead_zone;
    longint prev_err, err_sum, angle_acc;
    logic [PosW-1:0] angle_q[$];
    int failures;

    function new();
      gain_p    = GainPRst;
      gain_i    = GainIRst;
      gain_d    = GainDRst;
      dead_zone = DeadZoneRst;
      prev_err  = 0;
      err_sum   = 0;
      angle_acc = longint'(StartAngleRst) * FracOne;
      failures  = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void apply_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_GAIN_P:    gain_p = longint'($signed(data));
        REG_GAIN_I:    gain_i = longint'($signed(data));
        REG_GAIN_D:    gain_d = longint'($signed(data));
        REG_DEAD_ZONE: dead_zone = longint'(data[DzW-1:0]);
        REG_START_ANGLE: begin
          // reload the accumulator, keep integral and previous error
          angle_acc = longint'($signed(data[PosW-1:0])) * FracOne;
        end
        default: ;
      endcase
    endfunction

    function void note_input(logic [InDataW-1:0] data);
      longint meas, targ, err, corr;
      logic [PosW-1:0] angle;
      meas = longint'($signed(data[PosW-1:0]));
      targ = longint'($signed(data[InDataW-1:PosW]));
      err = targ - meas;
      err_sum = clip(err_sum + err, SumMin, SumMax);
      corr = gain_p * err + gain_i * err_sum + gain_d * (err - prev_err);
      prev_err = err;
      if ((meas < 0 ? -meas : meas) < dead_zone) corr = 0;
      angle_acc = clip(angle_acc + corr, AccMin, AccMax);
      // signed division truncates toward zero
      angle = PosW'(clip(angle_acc / FracOne, OutMin, OutMax));
      angle_q.push_back(angle);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= ReportMax) $display("%s", msg);
    endfunction

    function void check_result(logic [PosW-1:0] got);
      logic [PosW-1:0] want;
      if (angle_q.size() == 0) begin
        flag($sformatf("unexpected angle_cmd %0d with no item pending", $signed(got)));
        return;
      end
      want = angle_q.pop_front();
      if (got !== want) begin
        flag($sformatf("angle_cmd mismatch: expected %0d, got %0d",
                       $signed(want), $signed(got)));
      end
    endfunction

    function int pending();
      return angle_q.size();
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // measured_pos, target_pos
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // angle_cmd
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;

  angle_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit steady = 1'b0;

  pid_angle_tracker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Receiver: stall pattern switches to a randomly chosen mode whenever its hold count runs out.
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_e;
  rx_mode_e    rx_mode  = RX_OPEN;
  int unsigned rx_hold  = 0;
  int unsigned rx_stall = 0;

  always @(negedge clk_i) begin
    if (rx_hold == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_hold = $urandom_range(32, 256);
    end else begin
      rx_hold--;
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_stall != 0) begin
          rx_stall--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 12);
        end
      end
    endcase
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input logic [PosW-1:0] meas, input logic [PosW-1:0] targ);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = steady ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 4) == 0) gap = 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {targ, meas};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Drop valid and wait until every angle command is back and the pipe is empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.apply_write(idx, data);
    @(negedge clk_i);
  endtask

  task automatic write_all(input logic [CfgDataW-1:0] gp, input logic [CfgDataW-1:0] gi,
                           input logic [CfgDataW-1:0] gd, input logic [CfgDataW-1:0] dz,
                           input logic [CfgDataW-1:0] sa, input bit junk);
    settle();
    cfg_write(REG_GAIN_P, gp);
    cfg_write(REG_GAIN_I, gi);
    cfg_write(REG_GAIN_D, gd);
    cfg_write(REG_DEAD_ZONE, dz);
    cfg_write(REG_START_ANGLE, sa);
    // unused indexes go last so any aliasing would clobber a live register
    if (junk) begin
      for (int k = REG_START_ANGLE + 1; k < (1 << CfgIdxW); k++) begin
        cfg_write(CfgIdxW'(k), CfgDataW'($urandom));
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CfgDataW-1:0] pick_setting(int r);
    logic [CfgDataW-1:0] v;
    logic [DzW-1:0] dz;
    logic [PosW-1:0] sa;
    v = CfgDataW'($urandom);
    case (r)
      REG_DEAD_ZONE: begin
        case ($urandom_range(0, 7))
          0:       dz = '0;
          1:       dz = DzMax;
          2:       dz = DzW'($urandom_range(0, DzMax));
          default: dz = DzW'($urandom_range(1, 8));
        endcase
        v[DzW-1:0] = dz;
      end
      REG_START_ANGLE: begin
        case ($urandom_range(0, 5))
          0:       sa = PosMin;
          1:       sa = PosMax;
          2, 3:    sa = PosW'($urandom_range(0, 200) - 100);
          default: sa = PosW'($urandom);
        endcase
        v[PosW-1:0] = sa;
      end
      default: begin
        case ($urandom_range(0, 7))
          0:       v = GainMax;
          1:       v = GainMin;
          2:       v = '0;
          3, 4:    v = CfgDataW'($urandom_range(0, 200) - 100);
          5, 6:    v = CfgDataW'($urandom_range(0, 8000) - 4000);
          default: v = CfgDataW'($urandom);
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [PosW-1:0] pick_pos(int unsigned dz);
    logic [PosW-1:0] p;
    int unsigned d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: p = PosW'($urandom);
      4, 5:       p = PosW'($urandom_range(0, 64) - 32);
      6:          p = $urandom_range(0, 1) ? PosMin : PosMax;
      default: begin
        // straddle the dead zone edge on either side of zero
        d = dz + $urandom_range(0, 2) - 1;
        p = $urandom_range(0, 1) ? PosW'(-d) : PosW'(d);
      end
    endcase
    return p;
  endfunction

  initial begin
    logic [PosW-1:0] meas, targ;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: dead zone edges and error extremes
    send_item(16'sd0, 16'sd0);
    send_item(16'sd2, 16'sd100);
    send_item(-16'sd2, -16'sd100);
    send_item(16'sd3, 16'sd50);
    send_item(-16'sd3, -16'sd50);
    send_item(PosMin, PosMax);
    send_item(PosMax, PosMin);
    send_item(PosMax, PosMax);
    send_item(PosMin, PosMin);

    // largest gains, no dead zone: drive the accumulator into its clamp
    write_all(GainMax, GainMax, GainMax, '0, CfgDataW'(PosMax), 1'b0);
    send_item(16'sd0, 16'sd1);
    send_item(PosMin, PosMax);
    send_item(PosMax, PosMin);
    send_item(16'sd1, 16'sd1);

    // most negative gains, widest dead zone
    write_all(GainMin, GainMin, GainMin, CfgDataW'(DzMax), CfgDataW'(PosMin), 1'b0);
    send_item(-16'sd32767, PosMax);
    send_item(PosMax, 16'sd0);
    send_item(PosMin, 16'sd5);
    send_item(16'sd100, -16'sd100);

    // tiny gain around a negative start angle: truncation toward zero
    write_all(CfgDataW'(1), '0, '0, '0, '1, 1'b1);
    send_item(16'sd0, 16'sd1);
    send_item(16'sd0, -16'sd1);
    send_item(16'sd5, 16'sd5);

    for (int ph = 0; ph < RandPhases; ph++) begin
      settle();
      for (int r = REG_GAIN_P; r <= REG_START_ANGLE; r++) begin
        if ($urandom_range(0, 1) != 0) cfg_write(CfgIdxW'(r), pick_setting(r));
      end
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(CfgIdxW'($urandom_range(REG_START_ANGLE + 1, (1 << CfgIdxW) - 1)),
                  CfgDataW'($urandom));
      end
      cfg_we_i <= 1'b0;
      repeat (PhaseItems) begin
        meas = pick_pos(32'(sb.dead_zone));
        // mostly tracking: target close to the measured position
        if ($urandom_range(0, 2) == 0) targ = pick_pos(32'(sb.dead_zone));
        else targ = PosW'(meas + $urandom_range(0, 40) - 20);
        send_item(meas, targ);
      end
    end

    // integral run with zero gains, then read the integral through gain_i
    write_all('0, '0, '0, '0, '0, 1'b0);
    steady = 1'b1;
    repeat (SoakUp) send_item(PosMin, PosMax);
    steady = 1'b0;
    write_all('0, '1, '0, '0, '0, 1'b0);
    send_item(16'sd100, 16'sd100);

    write_all('0, '0, '0, '0, '0, 1'b0);
    steady = 1'b1;
    repeat (SoakDown) send_item(PosMax, PosMin);
    steady = 1'b0;
    write_all('0, CfgDataW'(1), '0, '0, CfgDataW'(1), 1'b0);
    send_item(16'sd100, 16'sd100);

    settle();
    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pat_pkg.sv
rtl/pid_angle_tracker.sv
bench/pid_angle_tracker_tb.sv
